FILE: sv/periodic_timer_table_assert.svh
// ----------------------------------------------------------------------------
// periodic_timer_table_assert.svh
// assertion macros used by the timer table back end (ptt_back)
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_TABLE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define PTT_CHECK(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// property that must hold in the cycle after a trigger
`define PTT_CHECK_NEXT(name, trig, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

FILE: sv/ptt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// types, codes and sizes for the periodic timer table
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int DEF_TIMER_SLOTS = 16;
    localparam int CMD_DEPTH       = 2;
    localparam int RES_DEPTH       = 2;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int PERIOD_W = 32;
    localparam int NOW_W    = 40;
    localparam int DUE_W    = 41;

    // operation codes on the input word
    localparam logic [OP_W-1:0] OP_SET  = 2'd0;
    localparam logic [OP_W-1:0] OP_KILL = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    // command kinds after classification
    localparam logic [1:0] CMD_SET  = 2'd0;
    localparam logic [1:0] CMD_KILL = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [KEY_W-1:0]    timer_key;
        logic [PERIOD_W-1:0] period_ms;
        logic [NOW_W-1:0]    now_ms;
    } in_word_t;

    typedef struct packed {
        logic             fired;
        logic [KEY_W-1:0] fired_key;
        logic             status;
        logic             last;
    } out_word_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [KEY_W-1:0]    key;
        logic [PERIOD_W-1:0] period;
        logic [NOW_W-1:0]    now;
        logic [DUE_W-1:0]    due;
    } cmd_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [PERIOD_W-1:0] period;
        logic [DUE_W-1:0]    due;
    } entry_t;

endpackage

FILE: sv/ptt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_fifo
// small register queue, used for commands and for results
// ----------------------------------------------------------------------------
module ptt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: sv/ptt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_front
// accepts input words, decodes the operation, queues commands
// ----------------------------------------------------------------------------
module ptt_front
    import ptt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_word_t item,
    output logic     full,
    output cmd_t     cmd,
    output logic     cmd_empty,
    input  logic     cmd_pop
);

    cmd_t cmd_in;

    always_comb
    begin
        cmd_in.key    = item.timer_key;
        cmd_in.period = item.period_ms;
        cmd_in.now    = item.now_ms;
        // due time of a set, worked out ahead of the table
        cmd_in.due    = DUE_W'(item.now_ms) + DUE_W'(item.period_ms);
        unique case (item.operation)
            OP_SET:  cmd_in.kind = CMD_SET;
            OP_KILL: cmd_in.kind = CMD_KILL;
            OP_TICK: cmd_in.kind = CMD_TICK;
            default: cmd_in.kind = CMD_NOP;
        endcase
    end

    ptt_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd),
        .empty (cmd_empty)
    );

endmodule

FILE: sv/ptt_back.sv
`timescale 1ns / 1ps
`include "periodic_timer_table_assert.svh"
// ----------------------------------------------------------------------------
// ptt_back
// timer table and scan engine: carries out set, kill, tick and unused-code commands
// ----------------------------------------------------------------------------
module ptt_back
    import ptt_pkg::*;
#(
    parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  logic      cmd_empty,
    output logic      cmd_pop,
    output out_word_t res,
    output logic      res_push,
    input  logic      res_full
);

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // table storage, one read and one write port
    entry_t table_mem [TIMER_SLOTS];
    entry_t rd_data_reg;
    logic   mem_re, mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    entry_t mem_wdata;

    logic [1:0]             state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [TIMER_SLOTS-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                   issue_done_reg, issue_done_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [SLOT_W-1:0]      rd_slot_reg, rd_slot_next;
    logic                   hit_reg, hit_next;
    logic [SLOT_W-1:0]      hit_slot_reg, hit_slot_next;
    logic                   free_reg, free_next;
    logic [SLOT_W-1:0]      free_slot_reg, free_slot_next;
    logic                   best_reg, best_next;
    logic [SLOT_W-1:0]      best_slot_reg, best_slot_next;
    logic [KEY_W-1:0]       best_key_reg, best_key_next;
    logic [PERIOD_W-1:0]    best_period_reg, best_period_next;
    logic                   prev_reg, prev_next;
    logic [KEY_W-1:0]       prev_key_reg, prev_key_next;
    logic                   held_reg, held_next;
    logic [KEY_W-1:0]       held_key_reg, held_key_next;

    logic             slot_valid, key_match, slot_due, tick_cand, tick_better;
    logic             need_push, scan_start;
    logic [DUE_W-1:0] tick_due;

    // per-slot compare on the word read last cycle
    assign slot_valid  = valid_reg[rd_slot_reg];
    assign key_match   = slot_valid && (rd_data_reg.key == cmd_reg.key);
    assign slot_due    = slot_valid && (DUE_W'(cmd_reg.now) >= rd_data_reg.due);
    assign tick_cand   = slot_due && (!prev_reg || (rd_data_reg.key > prev_key_reg));
    assign tick_better = tick_cand && (!best_reg || (rd_data_reg.key < best_key_reg));
    assign tick_due    = DUE_W'(cmd_reg.now) + DUE_W'(best_period_reg);

    assign mem_re = (state_reg == ST_SCAN) && !issue_done_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        valid_next       = valid_reg;
        scan_idx_next    = scan_idx_reg;
        issue_done_next  = issue_done_reg;
        rd_pend_next     = mem_re;
        rd_slot_next     = mem_re ? scan_idx_reg : rd_slot_reg;
        hit_next         = hit_reg;
        hit_slot_next    = hit_slot_reg;
        free_next        = free_reg;
        free_slot_next   = free_slot_reg;
        best_next        = best_reg;
        best_slot_next   = best_slot_reg;
        best_key_next    = best_key_reg;
        best_period_next = best_period_reg;
        prev_next        = prev_reg;
        prev_key_next    = prev_key_reg;
        held_next        = held_reg;
        held_key_next    = held_key_reg;
        cmd_pop          = 1'b0;
        need_push        = 1'b0;
        scan_start       = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = best_slot_reg;
        mem_wdata        = '{key: best_key_reg, period: best_period_reg, due: tick_due};
        res              = '{fired: 1'b0, fired_key: '0, status: 1'b0, last: 1'b1};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    prev_next  = 1'b0;
                    held_next  = 1'b0;
                    scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (mem_re)
                begin
                    if (scan_idx_reg == LAST_SLOT)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (rd_pend_reg)
                begin
                    if (key_match)
                    begin
                        hit_next      = 1'b1;
                        hit_slot_next = rd_slot_reg;
                    end
                    if (!slot_valid && !free_reg)
                    begin
                        free_next      = 1'b1;
                        free_slot_next = rd_slot_reg;
                    end
                    if (tick_better)
                    begin
                        best_next        = 1'b1;
                        best_slot_next   = rd_slot_reg;
                        best_key_next    = rd_data_reg.key;
                        best_period_next = rd_data_reg.period;
                    end
                    if (rd_slot_reg == LAST_SLOT)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                case (cmd_reg.kind)
                    CMD_SET:
                    begin
                        need_push = 1'b1;
                        mem_wdata = '{key: cmd_reg.key, period: cmd_reg.period,
                                      due: cmd_reg.due};
                        mem_waddr = hit_reg ? hit_slot_reg : free_slot_reg;
                        if (!res_full)
                        begin
                            if (hit_reg || free_reg)
                            begin
                                mem_we                = 1'b1;
                                valid_next[mem_waddr] = 1'b1;
                            end
                            else
                            begin
                                res.status = 1'b1;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_KILL:
                    begin
                        need_push = 1'b1;
                        if (!res_full)
                        begin
                            if (hit_reg)
                            begin
                                valid_next[hit_slot_reg] = 1'b0;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_TICK:
                    begin
                        if (best_reg)
                        begin
                            // a new timer fired, so the held one is not the last
                            need_push = held_reg;
                            res = '{fired: 1'b1, fired_key: held_key_reg,
                                    status: 1'b0, last: 1'b0};
                            if (!held_reg || !res_full)
                            begin
                                mem_we        = 1'b1;
                                held_next     = 1'b1;
                                held_key_next = best_key_reg;
                                prev_next     = 1'b1;
                                prev_key_next = best_key_reg;
                                scan_start    = 1'b1;
                                state_next    = ST_SCAN;
                            end
                        end
                        else
                        begin
                            need_push = 1'b1;
                            if (held_reg)
                            begin
                                res = '{fired: 1'b1, fired_key: held_key_reg,
                                        status: 1'b0, last: 1'b1};
                            end
                            if (!res_full)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        need_push = 1'b1;
                        if (!res_full)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (scan_start)
        begin
            scan_idx_next   = '0;
            issue_done_next = 1'b0;
            hit_next        = 1'b0;
            free_next       = 1'b0;
            best_next       = 1'b0;
        end
    end

    assign res_push = need_push && !res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            best_reg       <= 1'b0;
            prev_reg       <= 1'b0;
            held_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            scan_idx_reg   <= scan_idx_next;
            issue_done_reg <= issue_done_next;
            rd_pend_reg    <= rd_pend_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            best_reg       <= best_next;
            prev_reg       <= prev_next;
            held_reg       <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        rd_slot_reg     <= rd_slot_next;
        hit_slot_reg    <= hit_slot_next;
        free_slot_reg   <= free_slot_next;
        best_slot_reg   <= best_slot_next;
        best_key_reg    <= best_key_next;
        best_period_reg <= best_period_next;
        prev_key_reg    <= prev_key_next;
        held_key_reg    <= held_key_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= table_mem[scan_idx_reg];
        end
    end

    `PTT_CHECK(a_push_in_finish, !res_push || (state_reg == ST_FINISH), "result outside finish")
    `PTT_CHECK(a_push_room, !res_push || !res_full, "result pushed into full queue")
    `PTT_CHECK(a_pop_in_idle, !cmd_pop || ((state_reg == ST_IDLE) && !cmd_empty), "bad command pop")
    `PTT_CHECK(a_tick_order, !((state_reg == ST_FINISH) && (cmd_reg.kind == CMD_TICK) && best_reg && prev_reg) || (best_key_reg > prev_key_reg), "tick keys not ascending")
    `PTT_CHECK_NEXT(a_scan_ends, (state_reg == ST_SCAN) && rd_pend_reg && (rd_slot_reg == LAST_SLOT), state_reg == ST_FINISH, "scan did not finish")

endmodule

FILE: sv/periodic_timer_table.sv
`timescale 1ns / 1ps
// set, kill and unused codes: the engine pops the command, scans all N = TIMER_SLOTS slots once, then finishes
// a tick scans the table again after each timer that fires, until a scan finds none due
// the result word can be popped in the cycle after the engine queues it
// one item in the table engine at a time; one table scan reads one slot per cycle
// reset: all timers disarmed, both queues empty; no clearing pass is needed
// ----------------------------------------------------------------------------
// periodic_timer_table
// table of repeating timers with set, kill and tick commands
// ----------------------------------------------------------------------------
module periodic_timer_table
    import ptt_pkg::*;
#(
    parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
    input  logic      clk,
    input  logic      rst_n,
    // input word queue side
    input  logic      push,
    input  in_word_t  item,
    output logic      full,
    // result word queue side
    input  logic      pop,
    output out_word_t result,
    output logic      empty
);

    // front to back command link
    cmd_t      cmd;
    logic      cmd_empty;
    logic      cmd_pop;

    // back to result queue link
    out_word_t res;
    logic      res_push;
    logic      res_full;

    // front: takes words, decodes operation, precomputes set due time
    ptt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop)
    );

    // back: scans the slot memory once per pass
    // set and kill look up the key and the lowest free slot in one pass
    // tick picks the smallest due key above the last fired key each pass,
    // so fired words come out in ascending key order
    ptt_back #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // result queue keeps the engine running while the consumer stalls, as long as it has room
    ptt_fifo #(
        .WIDTH ($bits(out_word_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives set, kill, tick and unused-code words into the periodic timer table and
// checks every result word against a typed word or a behavioral copy of the
// timer table, with random stalls on both queue sides
// ----------------------------------------------------------------------------
module testbench;
    import ptt_pkg::*;

    localparam int TIMER_SLOTS  = DEF_TIMER_SLOTS;
    localparam int RANDOM_ITEMS = 475;
    localparam int CALM_ITEMS   = 60;
    localparam int KEY_POOL     = 24;
    // longest tick: every slot fires, one full table scan per fired timer plus a final one
    localparam int DRAIN_CYCLES = (TIMER_SLOTS + 1) * (TIMER_SLOTS + 2) + 8;

    // code 3 has no meaning in the package, the block just acknowledges it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // words that can be read straight off the spec
    localparam out_word_t WORD_DONE    = '{fired: 1'b0, fired_key: '0, status: 1'b0,
                                           last: 1'b1};
    localparam out_word_t WORD_DROPPED = '{fired: 1'b0, fired_key: '0, status: 1'b1,
                                           last: 1'b1};

    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t want;
    } plan_row_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    in_word_t  item  = '0;
    logic      full;
    logic      pop   = 1'b0;
    out_word_t result;
    logic      empty;

    // shadow copy of the timer table
    bit              slot_on     [TIMER_SLOTS];
    logic [31:0]     slot_key    [TIMER_SLOTS];
    logic [31:0]     slot_period [TIMER_SLOTS];
    logic [DUE_W-1:0] slot_due   [TIMER_SLOTS];

    out_word_t step_words[$];    // words caused by the word just accepted
    out_word_t pending[$];       // words still owed by the block, oldest first

    plan_row_t   plan[$];
    logic [31:0] key_pool[KEY_POOL];
    logic [NOW_W-1:0] clock_ms;
    int          kill_pct;

    // traffic shaping shared by both queue sides
    bit calm  = 1'b0;    // end of run: no idling at all
    bit quiet = 1'b0;    // a stretch with no idling

    int mismatches = 0;
    int n_set      = 0;
    int n_drop     = 0;
    int n_kill     = 0;
    int n_tick     = 0;
    int n_unused   = 0;
    int n_fired    = 0;
    int max_burst  = 0;

    periodic_timer_table #(
        .TIMER_SLOTS(TIMER_SLOTS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .pop    (pop),
        .result (result),
        .empty  (empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // safety net well beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // timer table prediction
    // ------------------------------------------------------------------------

    // slot that holds an armed timer with this key, or -1
    function automatic int find_slot(logic [31:0] key);
        for (int i = 0; i < TIMER_SLOTS; i++)
            if (slot_on[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    // applies one accepted word to the shadow table and lists the words it causes
    function automatic void timer_table_step(in_word_t w);
        int               hit;
        int               best;
        bit [TIMER_SLOTS-1:0] taken;
        logic [DUE_W-1:0] now;
        out_word_t        word;

        step_words.delete();
        now = {1'b0, w.now_ms};
        hit = find_slot(w.timer_key);
        case (w.operation)
            OP_SET:
            begin
                n_set++;
                // re-arm in place, else take the lowest free slot
                if (hit < 0)
                    for (int i = 0; i < TIMER_SLOTS; i++)
                        if (!slot_on[i] && hit < 0)
                            hit = i;
                if (hit < 0)
                begin
                    n_drop++;
                    step_words.insert(step_words.size(), WORD_DROPPED);
                end
                else
                begin
                    slot_on[hit]     = 1'b1;
                    slot_key[hit]    = w.timer_key;
                    slot_period[hit] = w.period_ms;
                    slot_due[hit]    = now + {{(DUE_W - 32){1'b0}}, w.period_ms};
                    step_words.insert(step_words.size(), WORD_DONE);
                end
            end
            OP_KILL:
            begin
                n_kill++;
                // a missing key is acknowledged the same way
                if (hit >= 0)
                    slot_on[hit] = 1'b0;
                step_words.insert(step_words.size(), WORD_DONE);
            end
            OP_TICK:
            begin
                n_tick++;
                taken = '0;
                // pick due timers one at a time, smallest key first
                do
                begin
                    best = -1;
                    for (int i = 0; i < TIMER_SLOTS; i++)
                        if (slot_on[i] && !taken[i] && now >= slot_due[i])
                            if (best < 0 || slot_key[i] < slot_key[best])
                                best = i;
                    if (best >= 0)
                    begin
                        taken[best] = 1'b1;
                        // no catch-up, next due is one period from now
                        slot_due[best] = now + {{(DUE_W - 32){1'b0}}, slot_period[best]};
                        word.fired     = 1'b1;
                        word.fired_key = slot_key[best];
                        word.status    = 1'b0;
                        word.last      = 1'b0;
                        step_words.insert(step_words.size(), word);
                    end
                end
                while (best >= 0);
                if (step_words.size() == 0)
                    step_words.insert(step_words.size(), WORD_DONE);
                else
                begin
                    n_fired += step_words.size();
                    if (step_words.size() > max_burst)
                        max_burst = step_words.size();
                    word      = step_words.pop_back();
                    word.last = 1'b1;
                    step_words.insert(step_words.size(), word);
                end
            end
            default:
            begin
                n_unused++;
                step_words.insert(step_words.size(), WORD_DONE);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // holds the word on the input until the block takes it; push stays high
    task automatic send_word(in_word_t w, bit typed, out_word_t want);
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        timer_table_step(w);
        if (typed)
            pending.insert(pending.size(), want);
        else
            foreach (step_words[i])
                pending.insert(pending.size(), step_words[i]);
    endtask

    // random gap on the input side, with junk on the item bus meanwhile
    task automatic sender_gap();
        int           len;
        logic [127:0] noise;

        if (calm || quiet || $urandom_range(0, 99) >= 12)
            return;
        len   = $urandom_range(1, 17);
        noise = {$urandom, $urandom, $urandom, $urandom};
        push <= 1'b0;
        item <= noise[$bits(in_word_t)-1:0];
        repeat (len)
            @(posedge clk);
    endtask

    // sender waits until the block has handed back everything it owes
    task automatic hold_until_drained();
        push <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic plan_row_t row(logic [OP_W-1:0] op, logic [31:0] key,
                                      logic [31:0] period, logic [NOW_W-1:0] now,
                                      bit typed, out_word_t want);
        plan_row_t r;
        r.word.operation = op;
        r.word.timer_key = key;
        r.word.period_ms = period;
        r.word.now_ms    = now;
        r.typed          = typed;
        r.want           = want;
        return r;
    endfunction

    // random word: mostly small periods and a slowly moving clock so ticks fire
    function automatic in_word_t next_random_word();
        in_word_t w;
        int       pick;
        int       slot;

        w.operation = OP_TICK;
        w.timer_key = $urandom;
        w.period_ms = $urandom;
        w.now_ms    = {8'($urandom_range(0, 255)), $urandom};
        pick        = $urandom_range(0, 99);
        if (pick < 4)
            w.operation = OP_UNUSED;
        else if (pick < 4 + kill_pct)
        begin
            w.operation = OP_KILL;
            // mostly kill something that is armed so the table churns
            slot = $urandom_range(0, TIMER_SLOTS - 1);
            if ($urandom_range(0, 99) < 75 && slot_on[slot])
                w.timer_key = slot_key[slot];
            else if ($urandom_range(0, 99) < 80)
                w.timer_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        end
        else if (pick < 4 + kill_pct + 35)
        begin
            w.operation = OP_SET;
            if ($urandom_range(0, 99) < 85)
                w.timer_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 85)
                w.period_ms = $urandom_range(0, 40);
            else if (pick < 95)
                w.period_ms = $urandom;
            else
                w.period_ms = 32'hFFFF_FFFF;
            w.now_ms = clock_ms;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                // jump anywhere on the time line
                clock_ms = {8'($urandom_range(0, 255)), $urandom};
                w.now_ms = clock_ms;
            end
            else if (pick < 6)
                // stale tick from the past, clock not moved
                w.now_ms = clock_ms - $urandom_range(0, 50);
            else
            begin
                clock_ms = clock_ms + $urandom_range(0, 25);
                w.now_ms = clock_ms;
            end
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    function automatic void note_mismatch(string what, out_word_t want, out_word_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch, %s: expected fired %0b key %h status %0b last %0b,",
                     $realtime, what, want.fired, want.fired_key, want.status, want.last,
                     " got fired %0b key %h status %0b last %0b",
                     got.fired, got.fired_key, got.status, got.last);
    endfunction

    function automatic void check_word(out_word_t got);
        out_word_t want;

        if (pending.size() == 0)
        begin
            note_mismatch("result word with nothing expected", '0, got);
            return;
        end
        want = pending.pop_front();
        if (got.fired !== want.fired || got.fired_key !== want.fired_key ||
            got.status !== want.status || got.last !== want.last)
            note_mismatch("wrong result word", want, got);
    endfunction

    // pop side: sample at the edge, then pick the next pop level
    initial
    begin : result_side
        int stall_left;

        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                check_word(result);
            if (calm || stall_left == 0)
            begin
                pop <= 1'b1;
                if (!calm && !quiet && $urandom_range(0, 99) < 6)
                    stall_left = $urandom_range(1, 17);
            end
            else
            begin
                pop <= 1'b0;
                stall_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : input_side
        in_word_t w;

        for (int i = 0; i < TIMER_SLOTS; i++)
            slot_on[i] = 1'b0;
        clock_ms    = 40'd1000;
        kill_pct    = 25;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        // directed part, typed words where the answer is obvious
        plan.insert(plan.size(), row(OP_TICK, 32'd0, 32'd0, 40'd0, 1'b1, WORD_DONE));
        plan.insert(plan.size(), row(OP_KILL, 32'd5, 32'd0, 40'd0, 1'b1, WORD_DONE));
        plan.insert(plan.size(), row(OP_UNUSED, 32'd9, 32'd9, 40'd9, 1'b1, WORD_DONE));
        plan.insert(plan.size(), row(OP_SET, 32'd0, 32'd0, 40'd100, 1'b1, WORD_DONE));
        plan.insert(plan.size(), row(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'd0,
                                     1'b1, WORD_DONE));
        plan.insert(plan.size(), row(OP_SET, 32'd7, 32'd10, 40'd100, 1'b1, WORD_DONE));
        plan.insert(plan.size(), row(OP_SET, 32'd3, 32'd5, 40'd100, 1'b1, WORD_DONE));
        // keys 0, 3 and 7 due together, must come out in key order
        plan.insert(plan.size(), row(OP_TICK, 32'd0, 32'd0, 40'd110, 1'b0, '0));
        plan.insert(plan.size(), row(OP_KILL, 32'd3, 32'd0, 40'd0, 1'b1, WORD_DONE));
        // fill the rest of the table with keys stored in descending order
        for (int i = 0; i < 13; i++)
            plan.insert(plan.size(), row(OP_SET, 32'h8000_0000 - i * 32'h0101_0101, i,
                                         40'd200, 1'b1, WORD_DONE));
        // table full: new key dropped, present key still re-armed
        plan.insert(plan.size(), row(OP_SET, 32'd42, 32'd1, 40'd300, 1'b1, WORD_DROPPED));
        plan.insert(plan.size(), row(OP_SET, 32'd7, 32'd3, 40'd300, 1'b1, WORD_DONE));
        // latest possible time: all sixteen timers fire in one tick
        plan.insert(plan.size(), row(OP_TICK, 32'd0, 32'd0, 40'hFF_FFFF_FFFF, 1'b0, '0));

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            send_word(plan[i].word, plan[i].typed, plan[i].want);
            sender_gap();
        end
        hold_until_drained();

        // random part
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (n % 100 == 0)
                kill_pct = $urandom_range(10, 45);
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            if (n == RANDOM_ITEMS / 2)
                hold_until_drained();
            w = next_random_word();
            send_word(w, 1'b0, '0);
            sender_gap();
        end
        push <= 1'b0;

        // let everything owed come back, then watch for stray words
        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("run covered %0d sets (%0d dropped on a full table), %0d kills,",
                 n_set, n_drop, n_kill, " %0d ticks, %0d unused codes", n_tick, n_unused);
        $display("%0d timers fired in total, up to %0d from one tick, %0d mismatches",
                 n_fired, max_burst, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
